// File: src/assert_macros.svh
// shared assertion macros, clocked on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// overlapping implication check
`define ASSERT_IMPLY(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |-> (post), msg)

// next-cycle implication check
`define ASSERT_NEXT(label, pre, post, msg) \
	`ASSERT_CLK(label, (pre) |=> (post), msg)

`endif

// File: src/i2crm_pkg.sv
`default_nettype none

package i2crm_pkg;

	// field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DEV_ADDR_W = 7;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	// request codes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLLS      = 1'b1;

	// configuration reset values
	localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST  = 7'd19;
	localparam logic [BYTE_W-1:0]     ACK_POLLS_RST = 8'd3;

	// one quarter-bit tick with an optional request
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] reg_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              sda_in;
	} cmd_t;

	// line levels and status after one tick
	typedef struct packed {
		logic              scl;
		logic              sda_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rd_data;
		logic              addr_nack;
		logic              any_nack;
	} rsp_t;

endpackage

`default_nettype wire

// File: src/i2c_register_master.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+-------------------------------
// command  | cmd_valid  | cmd_stall  | cmd  (op, reg_addr, wr_data, sda_in)
// response | rsp_valid  | rsp_stall  | rsp  (scl, sda_low, busy_res, ...)
// config   | cfg_we     | -          | cfg_index, cfg_data
//
// every command transaction yields exactly one response transaction
// path: command register, then sequencer step into the response register
// one transaction per cycle is sustained while rsp_stall stays low
// a stalled response holds the sequencer and back-pressures the command side
// arst_n clears the sequencer, latches and configuration to their reset values
`default_nettype none
`include "assert_macros.svh"

module i2c_register_master (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_stall,
	input  wire i2crm_pkg::cmd_t                     cmd,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output i2crm_pkg::rsp_t                          rsp,
	input  wire logic                                cfg_we,
	input  wire logic [i2crm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [i2crm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import i2crm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ADDR_W,
		ST_ACK_ADDR,
		ST_REG,
		ST_ACK_REG,
		ST_DATA,
		ST_ACK_DATA,
		ST_RESTART,
		ST_ADDR_R,
		ST_ACK_RD,
		ST_RX,
		ST_NACK_OUT,
		ST_STOP
	} step_t;

	// configuration
	logic [DEV_ADDR_W-1:0] dev_addr_q;
	logic [BYTE_W-1:0]     ack_polls_q;

	// command register
	logic cmd_valid_s1;
	cmd_t cmd_s1;

	// sequencer state
	step_t             step_q, step_n;
	logic [1:0]        qtr_q, qtr_n;
	logic [2:0]        bit_q, bit_n;
	logic [BYTE_W-1:0] tx_q, tx_n;
	logic [BYTE_W-1:0] rx_q, rx_n;
	logic [BYTE_W-1:0] reg_q, reg_n;
	logic [BYTE_W-1:0] data_q, data_n;
	logic              read_q, read_n;
	logic [BYTE_W-1:0] poll_q, poll_n;
	logic              addr_nack_q, addr_nack_n;
	logic              any_nack_q, any_nack_n;
	logic              scl_n, sdl_n, done_n;

	// response register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic adv;

	// handshake: the sequencer steps when a tick waits and the response slot frees up
	assign adv       = cmd_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = cmd_valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// sequencer step for the tick in the command register
	always_comb begin
		step_t             cur;
		logic [1:0]        q;
		logic              mid;
		logic              first;
		logic [BYTE_W-1:0] rx_sh;
		logic [BYTE_W-1:0] poll_inc;

		step_n      = step_q;
		qtr_n       = qtr_q;
		bit_n       = bit_q;
		tx_n        = tx_q;
		rx_n        = rx_q;
		reg_n       = reg_q;
		data_n      = data_q;
		read_n      = read_q;
		poll_n      = poll_q;
		addr_nack_n = addr_nack_q;
		any_nack_n  = any_nack_q;
		scl_n       = 1'b1;
		sdl_n       = 1'b0;
		done_n      = 1'b0;
		cur         = step_q;
		q           = qtr_q;
		first       = 1'b0;
		rx_sh       = {tx_q[BYTE_W-2:0], cmd_s1.sda_in};
		poll_inc    = (poll_q == {BYTE_W{1'b1}}) ? poll_q : poll_q + BYTE_W'(1);

		// new request while idle: latch it and run the first start quarter now
		if (step_q == ST_IDLE && (cmd_s1.op == OP_WRITE || cmd_s1.op == OP_READ)) begin
			read_n      = (cmd_s1.op == OP_READ);
			reg_n       = cmd_s1.reg_addr;
			data_n      = cmd_s1.wr_data;
			addr_nack_n = 1'b0;
			any_nack_n  = 1'b0;
			cur         = ST_START;
			q           = 2'd0;
			step_n      = ST_START;
			qtr_n       = 2'd0;
			bit_n       = 3'd0;
			poll_n      = '0;
		end
		mid = (q == 2'd1) || (q == 2'd2);

		unique case (cur)
			ST_IDLE: begin
			end
			// start and repeated start conditions
			ST_START, ST_RESTART: begin
				first = (cur == ST_START);
				unique case (q)
					2'd0: begin
						scl_n = first;
						sdl_n = 1'b0;
					end
					2'd1: begin
						scl_n = 1'b1;
						sdl_n = first;
					end
					2'd2: begin
						scl_n = 1'b1;
						sdl_n = 1'b1;
					end
					default: begin
						scl_n = 1'b0;
						sdl_n = 1'b1;
					end
				endcase
				if (q == 2'd3) begin
					step_n = first ? ST_ADDR_W : ST_ADDR_R;
					qtr_n  = 2'd0;
					bit_n  = 3'd0;
					poll_n = '0;
					tx_n   = {dev_addr_q, !first};
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// byte out, msb first
			ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
				scl_n = mid;
				sdl_n = !tx_q[BYTE_W-1];
				if (q == 2'd3) begin
					tx_n = {tx_q[BYTE_W-2:0], 1'b0};
					if (bit_q == 3'd7) begin
						unique case (cur)
							ST_ADDR_W: step_n = ST_ACK_ADDR;
							ST_REG:    step_n = ST_ACK_REG;
							ST_DATA:   step_n = ST_ACK_DATA;
							default:   step_n = ST_ACK_RD;
						endcase
						qtr_n  = 2'd0;
						bit_n  = 3'd0;
						poll_n = '0;
					end else begin
						bit_n = bit_q + 3'd1;
						qtr_n = 2'd0;
					end
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// acknowledge slot, polled while scl is high
			ST_ACK_ADDR, ST_ACK_REG, ST_ACK_DATA, ST_ACK_RD: begin
				scl_n = mid;
				sdl_n = 1'b0;
				if (q == 2'd2) begin
					if (!cmd_s1.sda_in) begin
						qtr_n = 2'd3;
					end else begin
						poll_n = poll_inc;
						if (poll_inc >= ack_polls_q) begin
							any_nack_n = 1'b1;
							if (cur == ST_ACK_ADDR) begin
								addr_nack_n = 1'b1;
							end
							qtr_n = 2'd3;
						end
					end
				end else if (q == 2'd3) begin
					qtr_n  = 2'd0;
					bit_n  = 3'd0;
					poll_n = '0;
					unique case (cur)
						ST_ACK_ADDR: begin
							step_n = ST_REG;
							tx_n   = reg_q;
						end
						ST_ACK_REG: begin
							if (read_q) begin
								step_n = ST_RESTART;
							end else begin
								step_n = ST_DATA;
								tx_n   = data_q;
							end
						end
						ST_ACK_DATA: step_n = ST_STOP;
						default: begin
							step_n = ST_RX;
							tx_n   = '0;
						end
					endcase
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// byte in, sampled in the second high quarter
			ST_RX: begin
				scl_n = mid;
				sdl_n = 1'b0;
				if (q == 2'd2) begin
					tx_n = rx_sh;
				end
				if (q == 2'd3) begin
					if (bit_q == 3'd7) begin
						rx_n   = tx_q;
						step_n = ST_NACK_OUT;
						qtr_n  = 2'd0;
						bit_n  = 3'd0;
						poll_n = '0;
					end else begin
						bit_n = bit_q + 3'd1;
						qtr_n = 2'd0;
					end
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// master nack after the received byte
			ST_NACK_OUT: begin
				scl_n = mid;
				sdl_n = 1'b0;
				if (q == 2'd3) begin
					step_n = ST_STOP;
					qtr_n  = 2'd0;
					bit_n  = 3'd0;
					poll_n = '0;
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// stop condition
			ST_STOP: begin
				if (q == 2'd0) begin
					scl_n = 1'b0;
					sdl_n = 1'b1;
				end else if (q == 2'd3) begin
					scl_n  = 1'b1;
					sdl_n  = 1'b0;
					done_n = 1'b1;
				end else begin
					scl_n = 1'b1;
					sdl_n = 1'b1;
				end
				if (q == 2'd3) begin
					step_n = ST_IDLE;
					qtr_n  = 2'd0;
					bit_n  = 3'd0;
					poll_n = '0;
				end else begin
					qtr_n = q + 2'd1;
				end
			end
			// unused step codes fall back to idle with lines released
			default: begin
				step_n = ST_IDLE;
				qtr_n  = 2'd0;
				bit_n  = 3'd0;
				poll_n = '0;
			end
		endcase
	end

	// registers: configuration, command stage, sequencer and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= DEV_ADDR_RST;
			ack_polls_q  <= ACK_POLLS_RST;
			cmd_valid_s1 <= 1'b0;
			cmd_s1       <= '0;
			step_q       <= ST_IDLE;
			qtr_q        <= 2'd0;
			bit_q        <= 3'd0;
			tx_q         <= '0;
			rx_q         <= '0;
			reg_q        <= '0;
			data_q       <= '0;
			read_q       <= 1'b0;
			poll_q       <= '0;
			addr_nack_q  <= 1'b0;
			any_nack_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data[DEV_ADDR_W-1:0];
					CFG_ACK_POLLS:      ack_polls_q <= cfg_data[BYTE_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd_valid && !cmd_stall) begin
				cmd_s1 <= cmd;
			end
			cmd_valid_s1 <= (cmd_valid && !cmd_stall) || (cmd_valid_s1 && !adv);
			if (adv) begin
				step_q            <= step_n;
				qtr_q             <= qtr_n;
				bit_q             <= bit_n;
				tx_q              <= tx_n;
				rx_q              <= rx_n;
				reg_q             <= reg_n;
				data_q            <= data_n;
				read_q            <= read_n;
				poll_q            <= poll_n;
				addr_nack_q       <= addr_nack_n;
				any_nack_q        <= any_nack_n;
				rsp_q.scl         <= scl_n;
				rsp_q.sda_low     <= sdl_n;
				rsp_q.busy_res    <= (step_n != ST_IDLE);
				rsp_q.done_res    <= done_n;
				rsp_q.rd_data     <= rx_n;
				rsp_q.addr_nack   <= addr_nack_n;
				rsp_q.any_nack    <= any_nack_n;
			end
			rsp_valid_q <= adv || (rsp_valid_q && rsp_stall);
		end
	end

	// assertions
	`ASSERT_NEXT(a_stop_to_idle, adv && step_q == ST_STOP && qtr_q == 2'd3,
		step_q == ST_IDLE, "stop did not return the sequencer to idle")
	`ASSERT_IMPLY(a_idle_clean, step_q == ST_IDLE,
		qtr_q == 2'd0 && bit_q == 3'd0, "idle sequencer holds stale counters")
	`ASSERT_IMPLY(a_poll_in_ack, !(step_q == ST_ACK_ADDR || step_q == ST_ACK_REG ||
		step_q == ST_ACK_DATA || step_q == ST_ACK_RD), poll_q == '0,
		"poll count left over outside an acknowledge slot")
	`ASSERT_IMPLY(a_done_not_busy, rsp_valid_q && rsp_q.done_res,
		!rsp_q.busy_res, "done reported while still busy")

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import i2crm_pkg::*;

	// spare request code, behaves as a plain tick
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	// sequencer steps of the bus engine
	typedef enum logic [4:0] {
		S_IDLE      = 5'd0,
		S_START     = 5'd1,
		S_ADDR_W    = 5'd2,
		S_ACK_ADDR  = 5'd3,
		S_REG       = 5'd4,
		S_ACK_REG   = 5'd5,
		S_DATA      = 5'd6,
		S_ACK_DATA  = 5'd7,
		S_RESTART   = 5'd8,
		S_ADDR_R    = 5'd9,
		S_ACK_RD    = 5'd10,
		S_RX        = 5'd11,
		S_NACK_OUT  = 5'd12,
		S_STOP      = 5'd13
	} seq_step_t;

	// engine state plus the two configuration registers
	typedef struct packed {
		seq_step_t             step;
		logic [1:0]            qtr;
		logic [3:0]            bit_cnt;
		logic [7:0]            tx_sr;
		logic [7:0]            rx_byte;
		logic [7:0]            reg_byte;
		logic [7:0]            data_byte;
		logic                  rd_mode;
		logic [7:0]            polls;
		logic                  addr_nack;
		logic                  any_nack;
		logic [DEV_ADDR_W-1:0] dev_addr;
		logic [7:0]            ack_limit;
	} bus_state_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cmd_t       pending_cmds[$];
	rsp_t       predicted_rsp[$];
	bus_state_t plan_seq;
	bus_state_t track_seq;
	int unsigned mismatches = 0;
	int unsigned planned_ticks = 0;
	logic       cmd_fire = 1'b0;
	logic       steady = 1'b0;
	int unsigned send_idle = 0;
	int unsigned send_run = 0;
	int unsigned stall_left = 0;
	int unsigned stall_run = 0;

	i2c_register_master uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// move to a new step, loading the shift register where the step sends a byte
	function automatic void enter_step(inout bus_state_t m, input seq_step_t s);
		m.step = s;
		m.qtr = 2'd0;
		m.bit_cnt = 4'd0;
		m.polls = 8'd0;
		case (s)
			S_ADDR_W: m.tx_sr = {m.dev_addr, 1'b0};
			S_ADDR_R: m.tx_sr = {m.dev_addr, 1'b1};
			S_REG:    m.tx_sr = m.reg_byte;
			S_DATA:   m.tx_sr = m.data_byte;
			S_RX:     m.tx_sr = 8'd0;
			default: ;
		endcase
	endfunction

	// one quarter-bit tick: line levels and status it produces
	function automatic rsp_t bus_tick(inout bus_state_t m, input cmd_t c);
		rsp_t       r;
		logic [1:0] q;
		logic       mid;
		r = '0;
		r.scl = 1'b1;
		q = m.qtr;
		if (m.step == S_IDLE && (c.op == OP_WRITE || c.op == OP_READ)) begin
			m.rd_mode = (c.op == OP_READ);
			m.reg_byte = c.reg_addr;
			m.data_byte = c.wr_data;
			m.addr_nack = 1'b0;
			m.any_nack = 1'b0;
			enter_step(m, S_START);
			q = 2'd0;
		end
		mid = (q == 2'd1 || q == 2'd2);

		case (m.step)
			S_IDLE: ;
			S_START, S_RESTART: begin
				case (q)
					2'd0: begin
						r.scl = (m.step == S_START);
						r.sda_low = 1'b0;
					end
					2'd1: begin
						r.scl = 1'b1;
						r.sda_low = (m.step == S_START);
					end
					2'd2: begin
						r.scl = 1'b1;
						r.sda_low = 1'b1;
					end
					default: begin
						r.scl = 1'b0;
						r.sda_low = 1'b1;
					end
				endcase
				if (q == 2'd3) begin
					if (m.step == S_START) enter_step(m, S_ADDR_W);
					else enter_step(m, S_ADDR_R);
				end else m.qtr = q + 2'd1;
			end
			S_ADDR_W, S_REG, S_DATA, S_ADDR_R: begin
				r.scl = mid;
				r.sda_low = !m.tx_sr[7];
				if (q == 2'd3) begin
					m.tx_sr = m.tx_sr << 1;
					m.bit_cnt = m.bit_cnt + 4'd1;
					if (m.bit_cnt >= 4'd8) begin
						case (m.step)
							S_ADDR_W: enter_step(m, S_ACK_ADDR);
							S_REG:    enter_step(m, S_ACK_REG);
							S_DATA:   enter_step(m, S_ACK_DATA);
							default:  enter_step(m, S_ACK_RD);
						endcase
					end else m.qtr = 2'd0;
				end else m.qtr = q + 2'd1;
			end
			S_ACK_ADDR, S_ACK_REG, S_ACK_DATA, S_ACK_RD: begin
				r.scl = mid;
				r.sda_low = 1'b0;
				if (q == 2'd2) begin
					if (!c.sda_in) m.qtr = 2'd3;
					else begin
						if (m.polls < 8'd255) m.polls = m.polls + 8'd1;
						if (m.polls >= m.ack_limit) begin
							m.any_nack = 1'b1;
							if (m.step == S_ACK_ADDR) m.addr_nack = 1'b1;
							m.qtr = 2'd3;
						end
					end
				end else if (q == 2'd3) begin
					case (m.step)
						S_ACK_ADDR: enter_step(m, S_REG);
						S_ACK_REG: begin
							if (m.rd_mode) enter_step(m, S_RESTART);
							else enter_step(m, S_DATA);
						end
						S_ACK_DATA: enter_step(m, S_STOP);
						default:    enter_step(m, S_RX);
					endcase
				end else m.qtr = q + 2'd1;
			end
			S_RX: begin
				r.scl = mid;
				r.sda_low = 1'b0;
				if (q == 2'd2) m.tx_sr = {m.tx_sr[6:0], c.sda_in};
				if (q == 2'd3) begin
					m.bit_cnt = m.bit_cnt + 4'd1;
					if (m.bit_cnt >= 4'd8) begin
						m.rx_byte = m.tx_sr;
						enter_step(m, S_NACK_OUT);
					end else m.qtr = 2'd0;
				end else m.qtr = q + 2'd1;
			end
			S_NACK_OUT: begin
				r.scl = mid;
				r.sda_low = 1'b0;
				if (q == 2'd3) enter_step(m, S_STOP);
				else m.qtr = q + 2'd1;
			end
			S_STOP: begin
				if (q == 2'd0) begin
					r.scl = 1'b0;
					r.sda_low = 1'b1;
				end else if (q == 2'd3) begin
					r.scl = 1'b1;
					r.sda_low = 1'b0;
					r.done_res = 1'b1;
				end else begin
					r.scl = 1'b1;
					r.sda_low = 1'b1;
				end
				if (q == 2'd3) enter_step(m, S_IDLE);
				else m.qtr = q + 2'd1;
			end
			default: enter_step(m, S_IDLE);
		endcase

		r.busy_res = (m.step != S_IDLE);
		r.rd_data = m.rx_byte;
		r.addr_nack = m.addr_nack;
		r.any_nack = m.any_nack;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	// command driver: random idle bursts with stretches of back-to-back transactions
	always @(negedge clk) begin
		if (arst_n && (!cmd_valid || cmd_fire)) begin
			if (!steady && send_idle > 0) begin
				send_idle--;
				cmd_valid <= 1'b0;
			end else if (!steady && send_run == 0 && $urandom_range(0, 99) < 12) begin
				send_idle = $urandom_range(0, 13);
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				if (send_run > 0) send_run--;
				else if ($urandom_range(0, 49) == 0) send_run = $urandom_range(30, 150);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// response back-pressure in random bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (!steady && stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (!steady && stall_run == 0 && $urandom_range(0, 99) < 12) begin
				stall_left = $urandom_range(0, 13);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (stall_run > 0) stall_run--;
				else if ($urandom_range(0, 49) == 0) stall_run = $urandom_range(30, 150);
			end
		end
	end

	// response checking against the oldest prediction, prediction on each accepted command
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			cmd_fire <= 1'b0;
		end else begin
			cmd_fire <= cmd_valid && !cmd_stall;
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp.size() == 0) begin
					$error("response transaction with no prediction pending");
					mismatches++;
				end else begin
					want = predicted_rsp.pop_front();
					check_field("scl", want.scl, rsp.scl);
					check_field("sda_low", want.sda_low, rsp.sda_low);
					check_field("busy_res", want.busy_res, rsp.busy_res);
					check_field("done_res", want.done_res, rsp.done_res);
					check_field("rd_data", want.rd_data, rsp.rd_data);
					check_field("addr_nack", want.addr_nack, rsp.addr_nack);
					check_field("any_nack", want.any_nack, rsp.any_nack);
				end
			end
			if (cmd_valid && !cmd_stall) predicted_rsp.push_back(bus_tick(track_seq, cmd));
		end
	end

	task automatic push_tick(input cmd_t c);
		void'(bus_tick(plan_seq, c));
		pending_cmds.push_back(c);
		planned_ticks++;
	endtask

	// ticks while the bus is idle, plain and spare codes
	task automatic push_idle(input int unsigned n);
		cmd_t c;
		repeat (n) begin
			c.op = $urandom_range(0, 1) ? OP_TICK : OP_SPARE;
			c.reg_addr = 8'($urandom);
			c.wr_data = 8'($urandom);
			c.sda_in = 1'($urandom_range(0, 1));
			push_tick(c);
		end
	endtask

	// one register transaction; nack_slots bits: address, register, data, read address
	task automatic run_transfer(input logic [OP_W-1:0] op, input logic [7:0] reg_byte,
			input logic [7:0] data_byte, input logic [3:0] nack_slots, input logic [7:0] rx_byte,
			input int unsigned noise_pct);
		cmd_t c;
		c.op = op;
		c.reg_addr = reg_byte;
		c.wr_data = data_byte;
		c.sda_in = 1'($urandom_range(0, 1));
		push_tick(c);
		while (plan_seq.step != S_IDLE) begin
			c.reg_addr = 8'($urandom);
			c.wr_data = 8'($urandom);
			// requests while busy, also on the tick the stop completes
			if ($urandom_range(0, 99) < noise_pct ||
					(plan_seq.step == S_STOP && plan_seq.qtr == 2'd3 && $urandom_range(0, 1)))
				c.op = OP_W'($urandom_range(0, 3));
			else
				c.op = OP_TICK;
			case (plan_seq.step)
				S_ACK_ADDR: c.sda_in = nack_slots[0] ? 1'b1 : ($urandom_range(0, 3) == 0);
				S_ACK_REG:  c.sda_in = nack_slots[1] ? 1'b1 : ($urandom_range(0, 3) == 0);
				S_ACK_DATA: c.sda_in = nack_slots[2] ? 1'b1 : ($urandom_range(0, 3) == 0);
				S_ACK_RD:   c.sda_in = nack_slots[3] ? 1'b1 : ($urandom_range(0, 3) == 0);
				S_RX:       c.sda_in = rx_byte[3'd7 - plan_seq.bit_cnt[2:0]];
				default:    c.sda_in = 1'($urandom_range(0, 1));
			endcase
			push_tick(c);
		end
	endtask

	// hold the sender until every prediction is matched and the engine has settled
	task automatic wait_settled();
		while (pending_cmds.size() != 0 || predicted_rsp.size() != 0 || cmd_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_DEVICE_ADDRESS) begin
			plan_seq.dev_addr = value[DEV_ADDR_W-1:0];
			track_seq.dev_addr = value[DEV_ADDR_W-1:0];
		end else begin
			plan_seq.ack_limit = value;
			track_seq.ack_limit = value;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned stop_at;
		int unsigned pick;
		plan_seq = '0;
		plan_seq.step = S_IDLE;
		plan_seq.dev_addr = DEV_ADDR_RST;
		plan_seq.ack_limit = ACK_POLLS_RST;
		track_seq = plan_seq;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, byte extremes, nack in each slot
		push_idle(4);
		run_transfer(OP_READ, 8'hFF, 8'h00, 4'b0000, 8'hFF, 0);
		wait_settled();
		write_cfg(CFG_DEVICE_ADDRESS, 8'h00);
		write_cfg(CFG_ACK_POLLS, 8'd1);
		run_transfer(OP_READ, 8'h55, 8'hAA, 4'b1010, 8'hA5, 0);
		wait_settled();
		// top address with the unused bit set, longest acknowledge wait
		write_cfg(CFG_DEVICE_ADDRESS, 8'hFF);
		write_cfg(CFG_ACK_POLLS, 8'd255);
		run_transfer(OP_READ, 8'h3C, 8'hC3, 4'b0001, 8'h5A, 0);
		wait_settled();
		write_cfg(CFG_ACK_POLLS, 8'd0);
		run_transfer(OP_WRITE, 8'h00, 8'hFF, 4'b0111, 8'h00, 100);
		wait_settled();

		// random: mostly complete transactions, some idle noise, config phases in between
		stop_at = planned_ticks + 200;
		while (planned_ticks < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				wait_settled();
				if ($urandom_range(0, 2) != 0) write_cfg(CFG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
				case ($urandom_range(0, 19))
					0:       write_cfg(CFG_ACK_POLLS, 8'd0);
					1:       write_cfg(CFG_ACK_POLLS, 8'd255);
					2, 3:    write_cfg(CFG_ACK_POLLS, 8'd1);
					4, 5, 6: ;
					default: write_cfg(CFG_ACK_POLLS, CFG_DATA_W'($urandom_range(1, 6)));
				endcase
			end else if (pick < 14) begin
				push_idle($urandom_range(1, 20));
			end else begin
				run_transfer($urandom_range(0, 1) ? OP_WRITE : OP_READ, 8'($urandom),
					8'($urandom), ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'b0000,
					8'($urandom),
					($urandom_range(0, 2) == 0) ? 30 : (($urandom_range(0, 1) == 0) ? 5 : 0));
			end
		end

		// last part runs without idling on either side
		wait_settled();
		steady = 1'b1;
		write_cfg(CFG_DEVICE_ADDRESS, CFG_DATA_W'($urandom));
		write_cfg(CFG_ACK_POLLS, 8'd2);
		run_transfer(OP_READ, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), 10);
		push_idle(5);
		wait_settled();
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

endmodule
